// File: src/dpfd_pkg.sv
// Doorbell pulse frame decoder: shared types and constants.
// No dependencies; imported by every module of the block.
`default_nettype none

package dpfd_pkg;

    // Field widths
    localparam int TICKS_W  = 16;
    localparam int SCALE_W  = 8;
    localparam int US_W     = 16;
    localparam int SCALED_W = TICKS_W + SCALE_W;
    localparam int INDEX_W  = 7;
    localparam int WORD_W   = 32;
    localparam int STATUS_W = 3;
    localparam int ID_W     = 16;
    localparam int CHIME_W  = 2;
    localparam int SEQ_W    = 8;

    // Configuration port
    localparam int CFG_ADDR_W = 4;
    localparam int CFG_DATA_W = 32;
    localparam int REG_IDX_W  = 2;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_PULSE_SCALE   = 2'd0,
        REG_BIT_THRESHOLD = 2'd1,
        REG_MAX_PULSE     = 2'd2
    } t_reg_idx;

    localparam logic [SCALE_W-1:0] RESET_PULSE_SCALE   = 8'd30;
    localparam logic [US_W-1:0]    RESET_BIT_THRESHOLD = 16'd400;
    localparam logic [US_W-1:0]    RESET_MAX_PULSE     = 16'd1200;

    // Frame layout
    localparam logic [INDEX_W-1:0] FRAME_PULSES    = 7'd66;
    localparam logic [INDEX_W-1:0] LAST_DATA_PULSE = 7'd63;
    localparam logic [INDEX_W-1:0] INDEX_MAX       = 7'd127;

    // Chime byte codes
    localparam logic [7:0] CHIME_BYTE_ONE   = 8'hE0;
    localparam logic [7:0] CHIME_BYTE_TWO   = 8'h1C;
    localparam logic [7:0] CHIME_BYTE_THREE = 8'h03;

    localparam logic [CHIME_W-1:0] CHIME_NONE  = 2'd0;
    localparam logic [CHIME_W-1:0] CHIME_ONE   = 2'd1;
    localparam logic [CHIME_W-1:0] CHIME_TWO   = 2'd2;
    localparam logic [CHIME_W-1:0] CHIME_THREE = 2'd3;

    // Report status codes
    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK        = 3'd0,
        STATUS_BAD_COUNT = 3'd1,
        STATUS_TOO_LONG  = 3'd2,
        STATUS_REPEAT    = 3'd3,
        STATUS_MIDDLE    = 3'd4,
        STATUS_BAD_CHIME = 3'd5
    } t_status;

    // One classified pulse, passed from front to back
    typedef struct packed {
        logic is_data;
        logic bit_one;
        logic too_long;
        logic last;
        logic repeat_seen;
        logic count_ok;
    } t_pulse_cls;

endpackage

`default_nettype wire

// File: src/dpfd_front.sv
// Front end: accepts pulse beats, scales and classifies them, tracks pulse number.
// Depends on dpfd_pkg.
`default_nettype none

module dpfd_front (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic [dpfd_pkg::TICKS_W-1:0] i_pulse_ticks,
    input  wire logic                         i_last_pulse,
    input  wire logic                         i_repeat_seen,
    input  wire logic                         i_accept,
    input  wire logic [dpfd_pkg::SCALE_W-1:0] i_pulse_scale,
    input  wire logic [dpfd_pkg::US_W-1:0]    i_bit_threshold,
    input  wire logic [dpfd_pkg::US_W-1:0]    i_max_pulse,
    output dpfd_pkg::t_pulse_cls              o_cls
);
    import dpfd_pkg::*;

    logic [INDEX_W-1:0]  r_pulse_index;
    logic [INDEX_W-1:0]  n_pulse_index;
    logic [INDEX_W-1:0]  pulse_num;
    logic [SCALED_W-1:0] scaled;
    logic                above_thr;
    logic                above_max;

    // Pulse number of this beat, saturating
    assign pulse_num = (r_pulse_index == INDEX_MAX) ? INDEX_MAX
                                                    : r_pulse_index + 7'd1;

    // Scale and compare against thresholds
    assign scaled    = SCALED_W'(i_pulse_ticks) * SCALED_W'(i_pulse_scale);
    assign above_thr = scaled > SCALED_W'(i_bit_threshold);
    assign above_max = scaled > SCALED_W'(i_max_pulse);

    always_comb begin
        o_cls.is_data     = pulse_num[0] && (pulse_num <= LAST_DATA_PULSE);
        o_cls.bit_one     = above_thr;
        o_cls.too_long    = above_thr && above_max;
        o_cls.last        = i_last_pulse;
        o_cls.repeat_seen = i_repeat_seen;
        o_cls.count_ok    = (pulse_num == FRAME_PULSES);
    end

    // Pulse counter restarts after the last pulse of a capture
    always_comb begin
        n_pulse_index = r_pulse_index;
        if (i_accept) begin
            n_pulse_index = i_last_pulse ? '0 : pulse_num;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pulse_index <= '0;
        end else begin
            r_pulse_index <= n_pulse_index;
        end
    end

endmodule

`default_nettype wire

// File: src/dpfd_fifo.sv
// Short queue of classified pulses between front and back.
// Depends on dpfd_pkg for the entry type.
`default_nettype none

module dpfd_fifo #(
    parameter int DEPTH = 4
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire dpfd_pkg::t_pulse_cls i_data,
    input  wire logic          i_pop,
    output dpfd_pkg::t_pulse_cls o_data,
    output logic               o_full,
    output logic               o_empty
);
    import dpfd_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] PTR_LAST = AW'(DEPTH - 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

    t_pulse_cls    r_mem [DEPTH];
    logic [AW-1:0] r_wr_ptr;
    logic [AW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;
    logic [AW-1:0] n_wr_ptr;
    logic [AW-1:0] n_rd_ptr;
    logic [CW-1:0] n_count;

    assign o_full  = (r_count == CNT_FULL);
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];

    // Pointer and fill count updates
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + AW'(1);
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + AW'(1);
        end
        if (i_push && !i_pop) begin
            n_count = r_count + CW'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

`default_nettype wire

// File: src/dpfd_back.sv
// Back end: shifts decoded bits, checks the frame at its last pulse, holds the report.
// Depends on dpfd_pkg.
`default_nettype none

module dpfd_back (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cls_valid,
    input  wire dpfd_pkg::t_pulse_cls          i_cls,
    output logic                               o_cls_pop,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output logic [dpfd_pkg::STATUS_W-1:0]      o_status,
    output logic [dpfd_pkg::ID_W-1:0]          o_device_id,
    output logic [dpfd_pkg::CHIME_W-1:0]       o_chime,
    output logic [dpfd_pkg::SEQ_W-1:0]         o_report_seq
);
    import dpfd_pkg::*;

    logic [WORD_W-1:0]   r_bit_shift;
    logic                r_too_long;
    logic [SEQ_W-1:0]    r_seq;
    logic                r_out_valid;
    logic [STATUS_W-1:0] r_status;
    logic [ID_W-1:0]     r_device_id;
    logic [CHIME_W-1:0]  r_chime;
    logic [SEQ_W-1:0]    r_report_seq;

    logic [WORD_W-1:0]   word;
    logic                too_long_any;
    logic [7:0]          chime_byte;
    logic [CHIME_W-1:0]  chime_code;
    t_status             status;
    logic                out_free;
    logic                report;

    // Output register frees when empty or taken this cycle
    assign out_free  = !r_out_valid || i_out_ready;
    assign o_cls_pop = i_cls_valid && (!i_cls.last || out_free);
    assign report    = o_cls_pop && i_cls.last;

    // Word and flags including this beat
    assign word         = i_cls.is_data ? {r_bit_shift[WORD_W-2:0], i_cls.bit_one}
                                        : r_bit_shift;
    assign too_long_any = r_too_long || (i_cls.is_data && i_cls.too_long);
    assign chime_byte   = word[7:0];

    // Chime byte lookup
    always_comb begin
        case (chime_byte)
            CHIME_BYTE_ONE:   chime_code = CHIME_ONE;
            CHIME_BYTE_TWO:   chime_code = CHIME_TWO;
            CHIME_BYTE_THREE: chime_code = CHIME_THREE;
            default:          chime_code = CHIME_NONE;
        endcase
    end

    // Frame checks in priority order
    always_comb begin
        if (!i_cls.count_ok) begin
            status = STATUS_BAD_COUNT;
        end else if (too_long_any) begin
            status = STATUS_TOO_LONG;
        end else if (i_cls.repeat_seen) begin
            status = STATUS_REPEAT;
        end else if (word[15:8] != 8'h00) begin
            status = STATUS_MIDDLE;
        end else if (chime_code == CHIME_NONE) begin
            status = STATUS_BAD_CHIME;
        end else begin
            status = STATUS_OK;
        end
    end

    // Capture state and sequence counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bit_shift <= '0;
            r_too_long  <= 1'b0;
            r_seq       <= '0;
        end else if (o_cls_pop) begin
            if (i_cls.last) begin
                r_bit_shift <= '0;
                r_too_long  <= 1'b0;
                if (status == STATUS_OK) begin
                    r_seq <= r_seq + SEQ_W'(1);
                end
            end else begin
                r_bit_shift <= word;
                r_too_long  <= too_long_any;
            end
        end
    end

    // Report output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (report) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (report) begin
            r_status <= status;
            if (status == STATUS_OK) begin
                r_device_id  <= word[WORD_W-1:WORD_W-ID_W];
                r_chime      <= chime_code;
                r_report_seq <= r_seq;
            end else begin
                r_device_id  <= '0;
                r_chime      <= CHIME_NONE;
                r_report_seq <= '0;
            end
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_status     = r_status;
    assign o_device_id  = r_device_id;
    assign o_chime      = r_chime;
    assign o_report_seq = r_report_seq;

endmodule

`default_nettype wire

// File: src/doorbell_pulse_frame_decoder_unit.sv
// Doorbell pulse frame decoder, top level.
// Report path: the last pulse beat of a frame passes through the pulse queue, then its
// report is registered in the output register once that register is free.
// Throughput: one pulse beat per cycle; the front is held only when the pulse queue
// is full, which happens while a finished report waits in the output register.
// Reset (synchronous, active low) restores register defaults and clears control state.
`default_nettype none

module doorbell_pulse_frame_decoder_unit #(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // Configuration port
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [dpfd_pkg::CFG_ADDR_W-1:0] paddr,
    input  wire logic [dpfd_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [dpfd_pkg::CFG_DATA_W-1:0]      prdata,
    output logic                                 pready,
    // Pulse input
    input  wire logic                            i_in_valid,
    output logic                                 o_in_ready,
    input  wire logic [dpfd_pkg::TICKS_W-1:0]    i_pulse_ticks,
    input  wire logic                            i_last_pulse,
    input  wire logic                            i_repeat_seen,
    // Report output
    output logic                                 o_out_valid,
    input  wire logic                            i_out_ready,
    output logic [dpfd_pkg::STATUS_W-1:0]        o_status,
    output logic [dpfd_pkg::ID_W-1:0]            o_device_id,
    output logic [dpfd_pkg::CHIME_W-1:0]         o_chime,
    output logic [dpfd_pkg::SEQ_W-1:0]           o_report_seq
);
    import dpfd_pkg::*;

    logic [SCALE_W-1:0]   r_pulse_scale;
    logic [US_W-1:0]      r_bit_threshold;
    logic [US_W-1:0]      r_max_pulse;
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 cfg_write;

    t_pulse_cls           front_cls;
    t_pulse_cls           queue_cls;
    logic                 in_accept;
    logic                 queue_full;
    logic                 queue_empty;
    logic                 queue_pop;

    // Configuration registers
    assign pready    = 1'b1;
    assign reg_idx   = paddr[CFG_ADDR_W-1:2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pulse_scale   <= RESET_PULSE_SCALE;
            r_bit_threshold <= RESET_BIT_THRESHOLD;
            r_max_pulse     <= RESET_MAX_PULSE;
        end else if (cfg_write) begin
            case (reg_idx)
                REG_PULSE_SCALE:   r_pulse_scale   <= pwdata[SCALE_W-1:0];
                REG_BIT_THRESHOLD: r_bit_threshold <= pwdata[US_W-1:0];
                REG_MAX_PULSE:     r_max_pulse     <= pwdata[US_W-1:0];
                default: ;
            endcase
        end
    end

    // Register readback
    always_comb begin
        case (reg_idx)
            REG_PULSE_SCALE:   prdata = CFG_DATA_W'(r_pulse_scale);
            REG_BIT_THRESHOLD: prdata = CFG_DATA_W'(r_bit_threshold);
            REG_MAX_PULSE:     prdata = CFG_DATA_W'(r_max_pulse);
            default:           prdata = '0;
        endcase
    end

    // Front: classify each accepted beat
    assign o_in_ready = !queue_full;
    assign in_accept  = i_in_valid && o_in_ready;

    dpfd_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_pulse_ticks   (i_pulse_ticks),
        .i_last_pulse    (i_last_pulse),
        .i_repeat_seen   (i_repeat_seen),
        .i_accept        (in_accept),
        .i_pulse_scale   (r_pulse_scale),
        .i_bit_threshold (r_bit_threshold),
        .i_max_pulse     (r_max_pulse),
        .o_cls           (front_cls)
    );

    // Queue between front and back
    dpfd_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (in_accept),
        .i_data  (front_cls),
        .i_pop   (queue_pop),
        .o_data  (queue_cls),
        .o_full  (queue_full),
        .o_empty (queue_empty)
    );

    // Back: frame assembly and report
    dpfd_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cls_valid  (!queue_empty),
        .i_cls        (queue_cls),
        .o_cls_pop    (queue_pop),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_status     (o_status),
        .o_device_id  (o_device_id),
        .o_chime      (o_chime),
        .o_report_seq (o_report_seq)
    );

endmodule

`default_nettype wire
